// ===== src/spd_pkg.sv =====
`default_nettype none
package spd_pkg;

  localparam logic [7:0] SyncByte  = 8'h55;
  localparam logic [7:0] BcastAddr = 8'hFF;

  localparam logic [7:0]  NodeAddrRst   = 8'd1;
  localparam logic [7:0]  MaxLengthRst  = 8'd255;
  localparam logic [15:0] GapTimeoutRst = 16'd100;

  localparam logic [1:0] CfgNodeAddress = 2'd0;
  localparam logic [1:0] CfgMaxLength   = 2'd1;
  localparam logic [1:0] CfgGapTimeout  = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DEST = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t      event_kind;
    logic [7:0] payload_byte;
    logic       last_byte;
    logic [7:0] packet_length;
  } result_t;

  typedef struct packed {
    logic [7:0]  node_address;
    logic [7:0]  max_length;
    logic [15:0] gap_timeout;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/spd_in_stage.sv =====
`default_nettype none
module spd_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire spd_pkg::item_t in_item,
  output logic                item_valid,
  output spd_pkg::item_t      item,
  input  wire logic           item_take
);

  logic valid;
  spd_pkg::item_t item_reg;

  assign in_ready   = !valid || item_take;
  assign item_valid = valid;
  assign item       = item_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_reg <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/spd_core.sv =====
`default_nettype none
module spd_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire spd_pkg::cfg_t    cfg,
  input  wire logic             take,
  input  wire spd_pkg::item_t   item,
  output logic                  res_valid,
  output spd_pkg::result_t      res
);

  spd_pkg::phase_t phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [15:0] gap_count, gap_count_next;
  logic [15:0] gap_inc;
  logic [7:0]  left_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= spd_pkg::PH_HUNT;
      bytes_left   <= 8'd0;
      frame_length <= 8'd0;
      gap_count    <= 16'd0;
    end else if (take) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      frame_length <= frame_length_next;
      gap_count    <= gap_count_next;
    end
  end

  assign gap_inc  = (gap_count == 16'hFFFF) ? gap_count : gap_count + 16'd1;
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    frame_length_next = frame_length;
    gap_count_next    = gap_count;
    res_valid         = 1'b0;
    res.event_kind    = spd_pkg::KIND_DATA;
    res.payload_byte  = 8'd0;
    res.last_byte     = 1'b0;
    res.packet_length = 8'd0;

    if (item.opcode == spd_pkg::OP_TICK) begin
      if (phase != spd_pkg::PH_HUNT) begin
        gap_count_next = gap_inc;
        if (gap_inc > cfg.gap_timeout) begin
          phase_next      = spd_pkg::PH_HUNT;
          gap_count_next  = 16'd0;
          bytes_left_next = 8'd0;
          if (phase == spd_pkg::PH_DATA && bytes_left < frame_length) begin
            res_valid         = 1'b1;
            res.event_kind    = spd_pkg::KIND_ABORT;
            res.packet_length = frame_length;
          end
        end
      end
    end else begin
      gap_count_next = 16'd0;
      case (phase)
        spd_pkg::PH_HUNT: begin
          if (item.rx_byte == spd_pkg::SyncByte) begin
            phase_next = spd_pkg::PH_DEST;
          end
        end
        spd_pkg::PH_DEST: begin
          if (item.rx_byte == spd_pkg::BcastAddr || item.rx_byte == cfg.node_address) begin
            phase_next = spd_pkg::PH_LEN;
          end else begin
            phase_next = spd_pkg::PH_HUNT;
          end
        end
        spd_pkg::PH_LEN: begin
          if (item.rx_byte > cfg.max_length) begin
            phase_next = spd_pkg::PH_HUNT;
          end else if (item.rx_byte == 8'd0) begin
            frame_length_next = 8'd0;
            bytes_left_next   = 8'd0;
            phase_next        = spd_pkg::PH_HUNT;
            res_valid         = 1'b1;
            res.event_kind    = spd_pkg::KIND_EMPTY;
          end else begin
            frame_length_next = item.rx_byte;
            bytes_left_next   = item.rx_byte;
            phase_next        = spd_pkg::PH_DATA;
          end
        end
        spd_pkg::PH_DATA: begin
          if (bytes_left == 8'd0) begin
            phase_next = spd_pkg::PH_HUNT;
          end else begin
            bytes_left_next   = left_dec;
            res_valid         = 1'b1;
            res.event_kind    = spd_pkg::KIND_DATA;
            res.payload_byte  = item.rx_byte;
            res.last_byte     = (left_dec == 8'd0);
            res.packet_length = frame_length;
            if (left_dec == 8'd0) begin
              phase_next = spd_pkg::PH_HUNT;
            end
          end
        end
        default: begin
          phase_next = spd_pkg::PH_HUNT;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/spd_out_stage.sv =====
`default_nettype none
module spd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  output logic                  ready,
  input  wire logic             load,
  input  wire spd_pkg::result_t res,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output spd_pkg::result_t      out_res
);

  logic valid;
  spd_pkg::result_t res_reg;

  assign ready     = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = res_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_reg <= res;
    end
  end

endmodule
`default_nettype wire

// ===== src/serial_packet_deframer.sv =====
`default_nettype none
// Sync/address/length packet deframer. Each input item is a received byte or a
// one-millisecond tick; frames of sync 0x55, destination (0xFF or node_address),
// length (<= max_length) and payload come out as one item per payload byte
// (tlast on the final one), one item per empty packet and one per timed-out
// packet whose payload had started. One item is taken per cycle while the output
// side keeps up: it is held in an input register, the frame state updates in that
// cycle, and the result, if any, lands in an output register.
module serial_packet_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] payload_byte, [15:8] packet_length
  output logic [1:0]       m_tuser,   // [1:0] event_kind
  output logic             m_tlast,   // last_byte
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  spd_pkg::cfg_t    cfg;
  spd_pkg::item_t   in_item;
  spd_pkg::item_t   item;
  spd_pkg::result_t res;
  spd_pkg::result_t out_res;
  logic item_valid;
  logic take;
  logic out_ready;
  logic res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address <= spd_pkg::NodeAddrRst;
      cfg.max_length   <= spd_pkg::MaxLengthRst;
      cfg.gap_timeout  <= spd_pkg::GapTimeoutRst;
    end else if (cfg_we) begin
      case (cfg_index)
        spd_pkg::CfgNodeAddress: cfg.node_address <= cfg_data[7:0];
        spd_pkg::CfgMaxLength:   cfg.max_length   <= cfg_data[7:0];
        spd_pkg::CfgGapTimeout:  cfg.gap_timeout  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_item.opcode  = spd_pkg::opcode_t'(s_tuser);
  assign in_item.rx_byte = s_tdata;
  assign take = item_valid && out_ready;

  spd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (take)
  );

  spd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  spd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .ready     (out_ready),
    .load      (take && res_valid),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.packet_length, out_res.payload_byte};
  assign m_tuser = out_res.event_kind;
  assign m_tlast = out_res.last_byte;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == spd_pkg::KIND_DATA || m_tuser == spd_pkg::KIND_EMPTY ||
                  m_tuser == spd_pkg::KIND_ABORT))
    else $error("illegal event kind");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == spd_pkg::KIND_EMPTY) |-> (m_tdata == 16'd0 && !m_tlast))
    else $error("empty packet item carries data");

  a_abort_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == spd_pkg::KIND_ABORT) |->
      (!m_tlast && m_tdata[7:0] == 8'd0 && m_tdata[15:8] != 8'd0))
    else $error("malformed abort item");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
module tb;

  localparam int unsigned CycleLimit = 100_000;
  localparam logic [1:0] CfgSpare = 2'd3;  // unmapped register index
  localparam spd_pkg::result_t NoResult = '0;

  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_QUIET,
    ROW_TYPED
  } row_mode_t;

  typedef struct packed {
    spd_pkg::opcode_t op;
    logic [7:0]       data;
    logic [7:0]       reps;
    row_mode_t        mode;
    spd_pkg::result_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic        s_tuser = 1'b0; // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] payload_byte, [15:8] packet_length
  logic [1:0]  m_tuser;        // [1:0] event_kind
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // travels with each item so the checker knows how to treat it
  row_mode_t        row_mode = ROW_MODEL;
  spd_pkg::result_t row_want = '0;

  // deframer state and register copies
  spd_pkg::phase_t ph;
  logic [7:0]  bytes_due;
  logic [7:0]  frame_len;
  logic [15:0] idle_ticks;
  logic [7:0]  node_addr;
  logic [7:0]  len_limit;
  logic [15:0] tick_limit;

  // register values as the stimulus sees them
  logic [7:0]  drv_node = spd_pkg::NodeAddrRst;
  logic [7:0]  drv_max = spd_pkg::MaxLengthRst;
  logic [15:0] drv_tmo = spd_pkg::GapTimeoutRst;

  spd_pkg::result_t pending_results[$];
  int          mismatches = 0;
  int unsigned sent_items = 0;
  bit          calm = 1'b0;
  logic        hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned stall_left = 0;
  row_t        plan[25];

  serial_packet_deframer u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit deframe_step(input spd_pkg::opcode_t op, input logic [7:0] b,
                                      output spd_pkg::result_t r);
    bit started;
    r = '0;
    if (op == spd_pkg::OP_TICK) begin
      if (ph == spd_pkg::PH_HUNT) return 1'b0;
      if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
      if (idle_ticks > tick_limit) begin
        started = (ph == spd_pkg::PH_DATA) && (bytes_due < frame_len);
        ph = spd_pkg::PH_HUNT;
        idle_ticks = '0;
        bytes_due = '0;
        if (started) begin
          r.event_kind = spd_pkg::KIND_ABORT;
          r.packet_length = frame_len;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    idle_ticks = '0;
    case (ph)
      spd_pkg::PH_HUNT: if (b == spd_pkg::SyncByte) ph = spd_pkg::PH_DEST;
      spd_pkg::PH_DEST: ph = (b == spd_pkg::BcastAddr || b == node_addr) ?
                             spd_pkg::PH_LEN : spd_pkg::PH_HUNT;
      spd_pkg::PH_LEN: begin
        if (b > len_limit) begin
          ph = spd_pkg::PH_HUNT;
        end else if (b == 8'd0) begin
          frame_len = '0;
          bytes_due = '0;
          ph = spd_pkg::PH_HUNT;
          r.event_kind = spd_pkg::KIND_EMPTY;
          return 1'b1;
        end else begin
          frame_len = b;
          bytes_due = b;
          ph = spd_pkg::PH_DATA;
        end
      end
      default: begin
        if (bytes_due == 8'd0) begin
          ph = spd_pkg::PH_HUNT;
        end else begin
          bytes_due = bytes_due - 8'd1;
          r.event_kind = spd_pkg::KIND_DATA;
          r.payload_byte = b;
          r.last_byte = (bytes_due == 8'd0);
          r.packet_length = frame_len;
          if (bytes_due == 8'd0) ph = spd_pkg::PH_HUNT;
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic note_mismatch(string what, logic [15:0] want_v, logic [15:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h got %0h", what, want_v, got_v);
  endtask

  always @(posedge clk) begin : scoreboard
    spd_pkg::result_t want;
    bit hit;
    if (rst) begin
      ph = spd_pkg::PH_HUNT;
      bytes_due = '0;
      frame_len = '0;
      idle_ticks = '0;
      node_addr = spd_pkg::NodeAddrRst;
      len_limit = spd_pkg::MaxLengthRst;
      tick_limit = spd_pkg::GapTimeoutRst;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spd_pkg::CfgNodeAddress: node_addr = cfg_data[7:0];
          spd_pkg::CfgMaxLength:   len_limit = cfg_data[7:0];
          spd_pkg::CfgGapTimeout:  tick_limit = cfg_data;
          default: ;
        endcase
      end
      // output first: a result at this edge belongs to an older item
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("item with none pending", '0, m_tdata);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.event_kind)
            note_mismatch("event_kind", 16'(want.event_kind), 16'(m_tuser));
          if (m_tdata[7:0] !== want.payload_byte)
            note_mismatch("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]));
          if (m_tlast !== want.last_byte)
            note_mismatch("last_byte", 16'(want.last_byte), 16'(m_tlast));
          if (m_tdata[15:8] !== want.packet_length)
            note_mismatch("packet_length", 16'(want.packet_length), 16'(m_tdata[15:8]));
        end
      end
      if (s_tvalid && s_tready) begin
        hit = deframe_step(spd_pkg::opcode_t'(s_tuser), s_tdata, want);
        if (row_mode == ROW_TYPED) begin
          hit = 1'b1;
          want = row_want;
        end else if (row_mode == ROW_QUIET) begin
          hit = 1'b0;
        end
        if (hit) pending_results.push_back(want);
      end
    end
  end

  // output side: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      stall_left <= 79;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(5) == 0) begin
      stall_left <= $urandom_range(7, 0);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb failed");
    $finish;
  end

  task automatic offer(spd_pkg::opcode_t op, logic [7:0] b, row_mode_t md = ROW_MODEL,
                       spd_pkg::result_t w = '0);
    int unsigned idle;
    if (!calm && $urandom_range(3) == 0) begin
      idle = $urandom_range(8, 1);
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= b;
    row_mode <= md;
    row_want <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  // wait for the block to drain, including items that cause no result
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] node, logic [7:0] maxl, logic [15:0] tmo);
    logic [7:0] junk;
    drv_node = node;
    drv_max = maxl;
    drv_tmo = tmo;
    junk = 8'($urandom_range(255));
    cfg_we <= 1'b1;
    cfg_index <= spd_pkg::CfgNodeAddress;
    cfg_data <= {junk, node};
    @(posedge clk);
    junk = 8'($urandom_range(255));
    cfg_index <= spd_pkg::CfgMaxLength;
    cfg_data <= {junk, maxl};
    @(posedge clk);
    cfg_index <= spd_pkg::CfgGapTimeout;
    cfg_data <= tmo;
    @(posedge clk);
    cfg_index <= CfgSpare;
    cfg_data <= 16'($urandom_range(65535));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic inter_byte_ticks();
    int unsigned k;
    k = 0;
    if (drv_tmo <= 16) begin
      if ($urandom_range(3) == 0) k = $urandom_range(drv_tmo + 1);
    end else if (drv_tmo <= 300 && $urandom_range(63) == 0) begin
      k = drv_tmo + $urandom_range(1);
    end else if ($urandom_range(3) == 0) begin
      k = $urandom_range(3, 1);
    end
    repeat (k) offer(spd_pkg::OP_TICK, 8'($urandom_range(255)));
  endtask

  task automatic send_frame(bit last);
    int unsigned pick, len, n;
    logic [7:0] dst;
    calm = last || ($urandom_range(5) == 0);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(3, 1))
        offer(spd_pkg::opcode_t'($urandom_range(1)), 8'($urandom_range(255)));
    offer(spd_pkg::OP_BYTE, spd_pkg::SyncByte);
    inter_byte_ticks();
    pick = $urandom_range(7);
    if (pick == 0) dst = 8'($urandom_range(255));
    else if (pick < 3) dst = spd_pkg::BcastAddr;
    else dst = drv_node;
    offer(spd_pkg::OP_BYTE, dst);
    inter_byte_ticks();
    pick = $urandom_range(15);
    if (pick == 0) len = $urandom_range(255);
    else if (pick == 1) len = drv_max;
    else len = $urandom_range(drv_max < 12 ? drv_max : 12);
    offer(spd_pkg::OP_BYTE, len[7:0]);
    // now and then the frame is cut short
    n = ($urandom_range(7) == 0) ? $urandom_range(len) : len;
    for (int i = 0; i < n; i++) begin
      inter_byte_ticks();
      offer(spd_pkg::OP_BYTE, 8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int unsigned target;
    plan = '{
      '{spd_pkg::OP_TICK, 8'hA5, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h00, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h55, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'hFF, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h00, 8'd1,   ROW_TYPED,
        '{spd_pkg::KIND_EMPTY, 8'h00, 1'b0, 8'd0}},
      '{spd_pkg::OP_BYTE, 8'h55, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h01, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h02, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'hFF, 8'd1,   ROW_TYPED,
        '{spd_pkg::KIND_DATA, 8'hFF, 1'b0, 8'd2}},
      '{spd_pkg::OP_BYTE, 8'h00, 8'd1,   ROW_TYPED,
        '{spd_pkg::KIND_DATA, 8'h00, 1'b1, 8'd2}},
      '{spd_pkg::OP_BYTE, 8'h55, 8'd1,   ROW_QUIET, NoResult},
      // wrong destination is consumed, not taken as a new sync
      '{spd_pkg::OP_BYTE, 8'h55, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'hFF, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h00, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h55, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'hFF, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h03, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'hA5, 8'd1,   ROW_TYPED,
        '{spd_pkg::KIND_DATA, 8'hA5, 1'b0, 8'd3}},
      '{spd_pkg::OP_TICK, 8'h00, 8'd100, ROW_QUIET, NoResult},
      '{spd_pkg::OP_TICK, 8'h00, 8'd1,   ROW_TYPED,
        '{spd_pkg::KIND_ABORT, 8'h00, 1'b0, 8'd3}},
      '{spd_pkg::OP_BYTE, 8'h55, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h01, 8'd1,   ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h05, 8'd1,   ROW_QUIET, NoResult},
      // timeout before any payload: silent drop
      '{spd_pkg::OP_TICK, 8'h00, 8'd101, ROW_QUIET, NoResult},
      '{spd_pkg::OP_BYTE, 8'h7E, 8'd1,   ROW_QUIET, NoResult}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 25; i++)
      for (int j = 0; j < plan[i].reps; j++)
        offer(plan[i].op, plan[i].data, plan[i].mode, plan[i].want);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(8'h00, 8'd0, 16'd0);
        1: set_config(spd_pkg::BcastAddr, 8'd255, 16'hFFFF);
        2: set_config(8'($urandom_range(255)), 8'd12, 16'd1);
        3: set_config(spd_pkg::SyncByte, 8'd6, 16'd4);
        4: set_config(8'($urandom_range(255)), 8'($urandom_range(40, 1)),
                      16'($urandom_range(20, 1)));
        default: set_config(spd_pkg::NodeAddrRst, spd_pkg::MaxLengthRst,
                            spd_pkg::GapTimeoutRst);
      endcase
      if (p == 1) begin
        // largest timeout: a run of ticks between bytes keeps the frame
        calm = 1'b1;
        offer(spd_pkg::OP_BYTE, spd_pkg::SyncByte);
        offer(spd_pkg::OP_BYTE, spd_pkg::BcastAddr);
        offer(spd_pkg::OP_BYTE, 8'd3);
        offer(spd_pkg::OP_BYTE, 8'($urandom_range(255)));
        repeat (40) offer(spd_pkg::OP_TICK, 8'($urandom_range(255)));
        repeat (2) offer(spd_pkg::OP_BYTE, 8'($urandom_range(255)));
        calm = 1'b0;
        // long output hold-off in the middle of a long payload
        offer(spd_pkg::OP_BYTE, spd_pkg::SyncByte);
        offer(spd_pkg::OP_BYTE, spd_pkg::BcastAddr);
        offer(spd_pkg::OP_BYTE, 8'd200);
        hold_req <= 1'b1;
        repeat (200) offer(spd_pkg::OP_BYTE, 8'($urandom_range(255)));
      end
      target = sent_items + 70;
      while (sent_items < target) send_frame(p == 5);
      settle();
    end

    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ===== serial_packet_deframer.f =====
src/spd_pkg.sv
src/spd_in_stage.sv
src/spd_core.sv
src/spd_out_stage.sv
src/serial_packet_deframer.sv
verif/tb.sv
